// ===== rtl/core/kear_pkg.sv =====
// Shared constants and types for the keypad edge and auto-repeat unit.
package kear_pkg;

    // Key line and register widths
    localparam int LINE_W       = 10;
    localparam int NUM_KEYS_DEF = 10;
    localparam int TIMER_W      = 8;
    localparam int CFG_W        = 8;
    localparam int CFG_IDX_W    = 1;

    localparam logic [TIMER_W-1:0] TIMER_MAX       = '1;
    localparam logic [CFG_W-1:0]   INIT_DELAY_RST  = CFG_W'(15);
    localparam logic [CFG_W-1:0]   REPEAT_PER_RST  = CFG_W'(5);

    // Word codes on the data channel
    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_DELAY = 1'b0,
        CFG_REPEAT_PERIOD = 1'b1
    } t_cfg_idx;

    // Per-key repeat phase
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_WAIT   = 2'd1,
        PH_REPEAT = 2'd2
    } t_phase;

    // Per-key control strobes from the top level
    typedef struct packed {
        logic tick;   // frame tick accepted
        logic clear;  // key newly pressed or not held on this tick
        logic query;  // key served by an accepted query and held
    } t_cell_ctl;

endpackage

// ===== rtl/core/kear_ifs.sv =====
// Channel interfaces: data words in, result words out, configuration writes.
interface kear_in_if
    import kear_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [LINE_W-1:0] key_lines;
    logic [LINE_W-1:0] query_mask;

    modport source (output valid, output op, output key_lines, output query_mask,
                    input ready);
    modport sink   (input valid, input op, input key_lines, input query_mask,
                    output ready);
endinterface

interface kear_out_if
    import kear_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [LINE_W-1:0] held_keys;
    logic [LINE_W-1:0] pressed_edges;
    logic [LINE_W-1:0] released_edges;
    logic [LINE_W-1:0] repeat_fire;

    modport source (output valid, output held_keys, output pressed_edges,
                    output released_edges, output repeat_fire, input ready);
    modport sink   (input valid, input held_keys, input pressed_edges,
                    input released_edges, input repeat_fire, output ready);
endinterface

interface kear_cfg_if
    import kear_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/kear_key_cell.sv =====
// One key's repeat timer and phase, with its fire-eligibility check.
module kear_key_cell
    import kear_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [CFG_W-1:0] i_initial_delay,
    input  logic [CFG_W-1:0] i_repeat_period,
    output logic             o_can_fire
);

    t_phase              r_phase;
    logic [TIMER_W-1:0]  r_timer;
    t_phase              n_phase;
    logic [TIMER_W-1:0]  n_timer;
    logic                w_delay_done;
    logic                w_period_done;

    assign w_delay_done  = (r_timer >= i_initial_delay);
    assign w_period_done = (r_timer >= i_repeat_period);

    // Fires on first query, after the delay, then every period
    always_comb begin
        unique case (r_phase)
            PH_FIRST:  o_can_fire = 1'b1;
            PH_WAIT:   o_can_fire = w_delay_done;
            PH_REPEAT: o_can_fire = w_period_done;
            default:   o_can_fire = 1'b0;
        endcase
    end

    // Next timer and phase
    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        if (i_ctl.tick) begin
            if (i_ctl.clear) begin
                n_phase = PH_FIRST;
                n_timer = '0;
            end else if (r_timer != TIMER_MAX) begin
                n_timer = r_timer + TIMER_W'(1);
            end
        end else if (i_ctl.query) begin
            unique case (r_phase)
                PH_FIRST: begin
                    n_phase = PH_WAIT;
                end
                PH_WAIT: begin
                    if (w_delay_done) begin
                        n_phase = PH_REPEAT;
                        n_timer = '0;
                    end
                end
                PH_REPEAT: begin
                    if (w_period_done) begin
                        n_timer = '0;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_timer <= '0;
        end else begin
            r_phase <= n_phase;
            r_timer <= n_timer;
        end
    end

endmodule

// ===== rtl/core/keypad_edge_and_auto_repeat_unit.sv =====
// Top level: keypad edge detection and typematic auto-repeat.
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    op, key_lines, query_mask
//  o_res     out  valid/ready    held_keys, pressed_edges, released_edges, repeat_fire
//  i_cfg     in   valid/ready    index, data (0 = initial_delay, 1 = repeat_period)
//
// One word per cycle while the result register is free; each result is registered and
// appears in the cycle after its word is taken. A new word is taken whenever the single
// result register is empty or its word is taken in the same cycle.
// Reset (synchronous, active low) clears key state and loads delay 15, period 5.
// Configuration writes are always taken.
module keypad_edge_and_auto_repeat_unit
    import kear_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kear_in_if.sink     i_in,
    kear_out_if.source  o_res,
    kear_cfg_if.sink    i_cfg
);

    localparam logic [LINE_W-1:0] KEY_MASK =
        (NUM_KEYS >= LINE_W) ? {LINE_W{1'b1}} : LINE_W'((1 << NUM_KEYS) - 1);

    logic [CFG_W-1:0]  r_initial_delay;
    logic [CFG_W-1:0]  r_repeat_period;
    logic [LINE_W-1:0] r_held;
    logic [LINE_W-1:0] r_pressed;
    logic [LINE_W-1:0] r_released;
    logic [LINE_W-1:0] r_fire;
    logic              r_out_valid;

    logic              w_accept;
    logic              w_tick;
    logic              w_query;
    logic [LINE_W-1:0] w_now;
    logic [LINE_W-1:0] w_diff;
    logic [LINE_W-1:0] n_pressed;
    logic [LINE_W-1:0] w_sel;
    logic [LINE_W-1:0] w_fire;
    logic [NUM_KEYS-1:0] w_can_fire;
    t_cell_ctl           w_ctl [NUM_KEYS];

    // Input handshake and word decode
    assign i_in.ready = !r_out_valid || o_res.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_tick     = w_accept && (t_op'(i_in.op) == OP_TICK);
    assign w_query    = w_accept && (t_op'(i_in.op) == OP_QUERY);

    // Edge detect on the active-low lines
    assign w_now     = ~i_in.key_lines & KEY_MASK;
    assign w_diff    = r_held ^ w_now;
    assign n_pressed = w_diff & w_now;

    // Lowest set key of the query mask
    assign w_sel = i_in.query_mask & (~i_in.query_mask + LINE_W'(1));

    // Per-key timers
    for (genvar i = 0; i < NUM_KEYS; i++) begin : g_key
        if (i < LINE_W) begin : g_line
            assign w_ctl[i].tick  = w_tick;
            assign w_ctl[i].clear = n_pressed[i] || !w_now[i];
            assign w_ctl[i].query = w_query && w_sel[i] && r_held[i];
        end else begin : g_noline
            // keys without a line are never held
            assign w_ctl[i].tick  = w_tick;
            assign w_ctl[i].clear = 1'b1;
            assign w_ctl[i].query = 1'b0;
        end

        kear_key_cell u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctl           (w_ctl[i]),
            .i_initial_delay (r_initial_delay),
            .i_repeat_period (r_repeat_period),
            .o_can_fire      (w_can_fire[i])
        );
    end

    // Fire vector: served key, held and eligible
    for (genvar i = 0; i < LINE_W; i++) begin : g_fire
        if (i < NUM_KEYS) begin : g_has_key
            assign w_fire[i] = w_sel[i] && r_held[i] && w_can_fire[i];
        end else begin : g_no_key
            assign w_fire[i] = 1'b0;
        end
    end

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_delay <= INIT_DELAY_RST;
            r_repeat_period <= REPEAT_PER_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_INITIAL_DELAY: r_initial_delay <= i_cfg.data;
                CFG_REPEAT_PERIOD: r_repeat_period <= i_cfg.data;
                default:           r_initial_delay <= r_initial_delay;
            endcase
        end
    end

    // Key state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_pressed   <= '0;
            r_released  <= '0;
            r_fire      <= '0;
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
            if (w_tick) begin
                r_held     <= w_now;
                r_pressed  <= n_pressed;
                r_released <= w_diff & r_held;
                r_fire     <= '0;
            end else begin
                r_fire     <= w_fire;
            end
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.held_keys      = r_held;
    assign o_res.pressed_edges  = r_pressed;
    assign o_res.released_edges = r_released;
    assign o_res.repeat_fire    = r_fire;

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the keypad edge and auto-repeat unit: self-checking random and directed run.
module tb;
    import kear_pkg::*;

    localparam int NKEYS       = NUM_KEYS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    // One result word as the block reports it
    typedef struct packed {
        logic [LINE_W-1:0] held_keys;
        logic [LINE_W-1:0] pressed_edges;
        logic [LINE_W-1:0] released_edges;
        logic [LINE_W-1:0] repeat_fire;
    } key_report_t;

    // Keypad state tracker and store of expected result words
    class keypad_scoreboard;
        logic [CFG_W-1:0]   delay_ticks;
        logic [CFG_W-1:0]   period_ticks;
        logic [LINE_W-1:0]  held_q;
        logic [LINE_W-1:0]  pressed_q;
        logic [LINE_W-1:0]  released_q;
        logic [TIMER_W-1:0] timer_q [NKEYS];
        t_phase             phase_q [NKEYS];
        key_report_t        pending_reports [$];
        int                 mismatch_count;
        int                 result_count;
        int                 fire_count;

        function new();
            delay_ticks    = INIT_DELAY_RST;
            period_ticks   = REPEAT_PER_RST;
            held_q         = '0;
            pressed_q      = '0;
            released_q     = '0;
            mismatch_count = 0;
            result_count   = 0;
            fire_count     = 0;
            for (int k = 0; k < NKEYS; k++) begin
                timer_q[k] = '0;
                phase_q[k] = PH_FIRST;
            end
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_INITIAL_DELAY: delay_ticks = value;
                CFG_REPEAT_PERIOD: period_ticks = value;
                default: ;
            endcase
        endfunction

        // Advance the keypad state by one accepted word and queue its result
        function void note_word(t_op op, logic [LINE_W-1:0] lines, logic [LINE_W-1:0] mask);
            logic [LINE_W-1:0] now_held;
            logic [LINE_W-1:0] diff;
            logic [LINE_W-1:0] fire;
            bit                served;
            key_report_t       rep;
            fire   = '0;
            served = 1'b0;
            if (op == OP_TICK) begin
                now_held   = ~lines;
                diff       = held_q ^ now_held;
                pressed_q  = diff & now_held;
                released_q = diff & held_q;
                held_q     = now_held;
                for (int k = 0; k < NKEYS; k++) begin
                    if (pressed_q[k] || !held_q[k]) begin
                        timer_q[k] = '0;
                        phase_q[k] = PH_FIRST;
                    end else if (timer_q[k] != TIMER_MAX) begin
                        timer_q[k] = timer_q[k] + 1'b1;
                    end
                end
            end else begin
                // only the lowest requested key is served
                for (int k = 0; k < NKEYS; k++) begin
                    if (!served && mask[k]) begin
                        served = 1'b1;
                        if (held_q[k]) begin
                            case (phase_q[k])
                                PH_FIRST: begin
                                    phase_q[k] = PH_WAIT;
                                    fire[k]    = 1'b1;
                                end
                                PH_WAIT: if (timer_q[k] >= delay_ticks) begin
                                    phase_q[k] = PH_REPEAT;
                                    timer_q[k] = '0;
                                    fire[k]    = 1'b1;
                                end
                                PH_REPEAT: if (timer_q[k] >= period_ticks) begin
                                    timer_q[k] = '0;
                                    fire[k]    = 1'b1;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end
            if (fire != '0) fire_count++;
            rep.held_keys      = held_q;
            rep.pressed_edges  = pressed_q;
            rep.released_edges = released_q;
            rep.repeat_fire    = fire;
            pending_reports.push_back(rep);
        endfunction

        // Compare one result word against the oldest expectation
        function void check_result(key_report_t got);
            key_report_t want;
            result_count++;
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display({"%0t: result word with none expected: ",
                              "held %h pressed %h released %h fire %h"},
                             $time, got.held_keys, got.pressed_edges, got.released_edges,
                             got.repeat_fire);
                return;
            end
            want = pending_reports.pop_front();
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("%0t: result word %0d mismatch (expected / actual)", $time,
                             result_count);
                    $display("  held %h / %h  pressed %h / %h  released %h / %h  fire %h / %h",
                             want.held_keys, got.held_keys, want.pressed_edges,
                             got.pressed_edges, want.released_edges, got.released_edges,
                             want.repeat_fire, got.repeat_fire);
                end
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    kear_in_if  in_if ();
    kear_out_if res_if ();
    kear_cfg_if cfg_if ();

    keypad_edge_and_auto_repeat_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    keypad_scoreboard  sb;
    bit                idle_on    = 1'b1;
    logic [LINE_W-1:0] lines_now  = '1;
    int                stall_left = 0;
    int                cycle_count = 0;
    int                words_sent  = 0;
    int                cfg_writes  = 0;

    always #1 i_clk = ~i_clk;

    // Result side: random stall bursts while idling is on
    always @(posedge i_clk) begin
        if (idle_on && stall_left > 0) begin
            stall_left    <= stall_left - 1;
            res_if.ready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left    <= $urandom_range(0, 18);
            res_if.ready  <= 1'b0;
        end else begin
            res_if.ready  <= 1'b1;
        end
    end

    // Check every result word taken
    always @(posedge i_clk) begin : result_monitor
        key_report_t got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.held_keys      = res_if.held_keys;
            got.pressed_edges  = res_if.pressed_edges;
            got.released_edges = res_if.released_edges;
            got.repeat_fire    = res_if.repeat_fire;
            sb.check_result(got);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Send one word, with an optional idle burst ahead of it
    task automatic send_word(t_op op, logic [LINE_W-1:0] lines, logic [LINE_W-1:0] mask);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.op         <= op;
        in_if.key_lines  <= lines;
        in_if.query_mask <= mask;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_word(op, lines, mask);
        if (op == OP_TICK) lines_now = lines;
        words_sent++;
    endtask

    // Stop sending and wait for every expected word
    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write both registers while the block is idle
    task automatic configure(logic [CFG_W-1:0] delay_val, logic [CFG_W-1:0] period_val);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_INITIAL_DELAY;
        cfg_if.data  <= delay_val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.set_reg(CFG_INITIAL_DELAY, delay_val);
        cfg_if.index <= CFG_REPEAT_PERIOD;
        cfg_if.data  <= period_val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        sb.set_reg(CFG_REPEAT_PERIOD, period_val);
        cfg_if.valid <= 1'b0;
        cfg_writes += 2;
    endtask

    // Random traffic: key lines mostly held steady, queries mostly aimed at held keys
    task automatic run_random(int n_words, int change_pm, int tick_pct);
        logic [LINE_W-1:0] lines;
        logic [LINE_W-1:0] mask;
        logic [LINE_W-1:0] held_view;
        logic [LINE_W-1:0] one_hot;
        int                k;
        int                pick;
        for (int w = 0; w < n_words; w++) begin
            lines = lines_now;
            mask  = LINE_W'($urandom_range(0, 1023));
            if ($urandom_range(0, 99) < tick_pct) begin
                if ($urandom_range(0, 999) < change_pm) begin
                    if ($urandom_range(0, 3) == 0) begin
                        lines = LINE_W'($urandom_range(0, 1023));
                    end else begin
                        k        = $urandom_range(0, NKEYS - 1);
                        lines[k] = ~lines[k];
                    end
                end
                send_word(OP_TICK, lines, mask);
            end else begin
                held_view = ~lines_now;
                pick      = $urandom_range(0, 9);
                k         = $urandom_range(0, NKEYS - 1);
                if (pick < 6) begin
                    repeat (NKEYS) if (!held_view[k]) k = $urandom_range(0, NKEYS - 1);
                end else if (pick == 9) begin
                    repeat (NKEYS) if (held_view[k]) k = $urandom_range(0, NKEYS - 1);
                end
                if (pick < 6 || pick == 9) begin
                    // chosen key is the lowest set bit, higher bits random
                    one_hot    = '0;
                    one_hot[k] = 1'b1;
                    mask       = (mask & ~((one_hot << 1) - LINE_W'(1))) | one_hot;
                end else if (pick == 8) begin
                    mask = '0;
                end
                send_word(OP_QUERY, LINE_W'($urandom_range(0, 1023)), mask);
            end
        end
    endtask

    initial begin
        sb = new();
        in_if.valid      <= 1'b0;
        in_if.op         <= OP_TICK;
        in_if.key_lines  <= '1;
        in_if.query_mask <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= CFG_INITIAL_DELAY;
        cfg_if.data      <= '0;
        i_rst_n          <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed at reset settings: empty mask, keys not held, edges, lowest-key service
        send_word(OP_TICK,  10'h3FF, 10'h000);
        send_word(OP_QUERY, 10'h000, 10'h000);
        send_word(OP_QUERY, 10'h000, 10'h001);
        send_word(OP_TICK,  10'h000, 10'h3FF);
        send_word(OP_TICK,  10'h000, 10'h000);
        send_word(OP_QUERY, 10'h3FF, 10'h3FF);
        send_word(OP_QUERY, 10'h000, 10'h200);
        send_word(OP_QUERY, 10'h000, 10'h001);
        send_word(OP_TICK,  10'h001, 10'h000);
        send_word(OP_QUERY, 10'h000, 10'h003);
        send_word(OP_TICK,  10'h000, 10'h000);
        send_word(OP_QUERY, 10'h000, 10'h001);
        send_word(OP_TICK,  10'h3FF, 10'h000);
        send_word(OP_QUERY, 10'h000, 10'h3FF);
        send_word(OP_TICK,  10'h155, 10'h000);
        send_word(OP_TICK,  10'h2AA, 10'h000);
        send_word(OP_QUERY, 10'h000, 10'h155);
        run_random(150, 100, 60);

        // Zero delay and period: a held key fires on every query
        configure(8'd0, 8'd0);
        send_word(OP_TICK,  10'h3FE, 10'h000);
        send_word(OP_QUERY, 10'h000, 10'h001);
        send_word(OP_QUERY, 10'h000, 10'h001);
        send_word(OP_QUERY, 10'h000, 10'h001);
        run_random(150, 100, 55);

        // Longest delay and period with keys held long enough for the timer to saturate
        configure(8'd255, 8'd255);
        run_random(350, 2, 90);

        configure(CFG_W'($urandom_range(1, 20)), CFG_W'($urandom_range(1, 8)));
        run_random(150, 60, 60);

        // Closing stretch at full rate, no idling on either side
        idle_on = 1'b0;
        configure(8'd2, 8'd1);
        run_random(150, 80, 55);

        drain();
        repeat (5) @(posedge i_clk);
        $display("run covered %0d words (%0d result words, %0d with a repeat fire)",
                 words_sent, sb.result_count, sb.fire_count);
        $display("%0d register writes, mismatches %0d, expected words left over %0d",
                 cfg_writes, sb.mismatch_count, sb.pending_reports.size());
        if (sb.mismatch_count == 0 && sb.pending_reports.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
